// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL modules of the LCD number writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/clnw_pkg.sv =====
// Shared types, codes, constants and helper functions of the LCD number writer.
package clnw_pkg;

   localparam int MAX_DIGITS_DEFAULT  = 16;
   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 2;

   // Division by ten: q = (n * RECIP_TEN) >> RECIP_SHIFT is exact for n below 2**32.
   localparam int          MUL_W       = 32;
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          QUOT_W      = 2 * MUL_W - RECIP_SHIFT;

   localparam logic [7:0] INIT_SEQ [4] = '{8'h38, 8'h0C, 8'h06, 8'h01};
   localparam logic [7:0] CURSOR_CMD   = 8'h80;
   localparam logic [7:0] LINE2_OFFSET = 8'h40;
   localparam logic [1:0] LINE_TOP     = 2'd1;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   typedef enum logic [2:0] {
      ACT_INIT = 3'd0,
      ACT_CHAR = 3'd1,
      ACT_UDEC = 3'd2,
      ACT_SDEC = 3'd3,
      ACT_BIN  = 3'd4,
      ACT_HEX  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_BIN = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   // Control part of one queued job; magnitude and digit count travel beside it.
   typedef struct packed {
      logic       is_init;
      logic       has_lead;
      base_type   base;
      logic [7:0] lead_char;
      logic [7:0] cursor;
   } job_ctrl_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] ch;
      if (d < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, d};
      end else begin
         ch = CHAR_A + {4'd0, d} - 8'd10;
      end
      return ch;
   endfunction

endpackage

// ===== sv/char_lcd_number_writer_unit.sv =====
// Top level of the LCD number writer: front end, job queue and write sequencer.
//
//   Channel   Ports                              Handshake
//   request   req_* fields, start, busy          taken when start is high and busy low
//   result    rsp_reg_select, rsp_bus_byte, ...  each write valid for a single cycle, marked by rsp_strobe
//
// An init transaction gives its four writes back to back after it leaves the queue.
// A number transaction writes the cursor command and the sign or character, if any, then
// converts every digit in a multiply step and a divide step (S_MUL, S_DIV) before it
// writes the digits in turn (S_DIGIT); decimal digits use the divide-by-ten unit.
// Reset clears the queue and the sequencer; results cannot be held off by the receiver.
// busy is high while the two-entry queue is full.
module char_lcd_number_writer_unit #(
   parameter int MAX_DIGITS  = clnw_pkg::MAX_DIGITS_DEFAULT,
   parameter int VALUE_WIDTH = clnw_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_line,
   input  logic [5:0]  req_column,
   input  logic [15:0] req_value,
   input  logic [4:0]  req_digit_count,
   input  logic [7:0]  req_char_code,
   output logic        rsp_strobe,
   output logic        rsp_reg_select,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_last
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int JOB_W = $bits(clnw_pkg::job_ctrl_type) + VALUE_WIDTH + CNT_W;

   logic                   push, pop, full, empty;
   clnw_pkg::job_ctrl_type front_ctrl, back_ctrl;
   logic [VALUE_WIDTH-1:0] front_mag, back_mag;
   logic [CNT_W-1:0]       front_count, back_count;
   logic [JOB_W-1:0]       q_wdata, q_rdata;

   assign busy    = full;
   assign q_wdata = {front_ctrl, front_mag, front_count};
   assign {back_ctrl, back_mag, back_count} = q_rdata;

   clnw_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W      (CNT_W)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_line       (req_line),
      .req_column     (req_column),
      .req_value      (req_value),
      .req_digit_count(req_digit_count),
      .req_char_code  (req_char_code),
      .push           (push),
      .job_ctrl       (front_ctrl),
      .job_mag        (front_mag),
      .job_count      (front_count)
   );

   clnw_queue #(
      .WIDTH(JOB_W),
      .DEPTH(clnw_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(q_wdata),
      .full     (full),
      .pop      (pop),
      .pop_data (q_rdata),
      .empty    (empty)
   );

   clnw_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W      (CNT_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (empty),
      .pop           (pop),
      .job_ctrl      (back_ctrl),
      .job_mag       (back_mag),
      .job_count     (back_count),
      .rsp_strobe    (rsp_strobe),
      .rsp_reg_select(rsp_reg_select),
      .rsp_bus_byte  (rsp_bus_byte),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== sv/clnw_front.sv =====
// Front end: accepts requests, classifies them and builds one job for the queue.
module clnw_front #(
   parameter int MAX_DIGITS  = clnw_pkg::MAX_DIGITS_DEFAULT,
   parameter int VALUE_WIDTH = clnw_pkg::VALUE_WIDTH_DEFAULT,
   parameter int CNT_W       = $clog2(MAX_DIGITS + 1)
) (
   input  logic                       start,
   input  logic                       busy,
   input  logic [2:0]                 req_action,
   input  logic [1:0]                 req_line,
   input  logic [5:0]                 req_column,
   input  logic [15:0]                req_value,
   input  logic [4:0]                 req_digit_count,
   input  logic [7:0]                 req_char_code,
   output logic                       push,
   output clnw_pkg::job_ctrl_type     job_ctrl,
   output logic [VALUE_WIDTH-1:0]     job_mag,
   output logic [CNT_W-1:0]           job_count
);

   logic [VALUE_WIDTH-1:0] val_n;
   logic                   val_neg;
   logic [7:0]             cursor;
   logic [CNT_W-1:0]       sat_count;
   logic                   known;

   assign val_n   = VALUE_WIDTH'(req_value);
   assign val_neg = val_n[VALUE_WIDTH-1];

   assign cursor = clnw_pkg::CURSOR_CMD | (8'(req_column) - 8'd1 +
                   ((req_line == clnw_pkg::LINE_TOP) ? 8'd0 : clnw_pkg::LINE2_OFFSET));

   assign sat_count = (32'(req_digit_count) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS)
                                                          : CNT_W'(req_digit_count);

   always_comb begin
      known              = 1'b1;
      job_ctrl.is_init   = 1'b0;
      job_ctrl.has_lead  = 1'b0;
      job_ctrl.base      = clnw_pkg::BASE_DEC;
      job_ctrl.lead_char = req_char_code;
      job_ctrl.cursor    = cursor;
      job_mag            = val_n;
      job_count          = sat_count;
      case (clnw_pkg::action_type'(req_action))
         clnw_pkg::ACT_INIT: begin
            job_ctrl.is_init = 1'b1;
            job_count        = '0;
         end
         clnw_pkg::ACT_CHAR: begin
            job_ctrl.has_lead = 1'b1;
            job_count         = '0;
         end
         clnw_pkg::ACT_UDEC: begin
            job_ctrl.base = clnw_pkg::BASE_DEC;
         end
         clnw_pkg::ACT_SDEC: begin
            // Zero counts as not positive and gets a minus sign.
            job_ctrl.has_lead = 1'b1;
            if (!val_neg && (val_n != '0)) begin
               job_ctrl.lead_char = clnw_pkg::CHAR_PLUS;
               job_mag            = val_n;
            end else begin
               job_ctrl.lead_char = clnw_pkg::CHAR_MINUS;
               job_mag            = val_neg ? (~val_n + VALUE_WIDTH'(1)) : '0;
            end
         end
         clnw_pkg::ACT_BIN: begin
            job_ctrl.base = clnw_pkg::BASE_BIN;
         end
         clnw_pkg::ACT_HEX: begin
            job_ctrl.base = clnw_pkg::BASE_HEX;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Undefined actions are accepted and dropped.
   assign push = start && !busy && known;

endmodule

// ===== sv/clnw_queue.sv =====
// Short job queue between the front end and the write sequencer.
module clnw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = clnw_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/clnw_back.sv =====
// Back end: digit conversion and sequencing of the LCD bus writes for one job.
`include "assert_macros.svh"

module clnw_back #(
   parameter int MAX_DIGITS  = clnw_pkg::MAX_DIGITS_DEFAULT,
   parameter int VALUE_WIDTH = clnw_pkg::VALUE_WIDTH_DEFAULT,
   parameter int CNT_W       = $clog2(MAX_DIGITS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   output logic                   pop,
   input  clnw_pkg::job_ctrl_type job_ctrl,
   input  logic [VALUE_WIDTH-1:0] job_mag,
   input  logic [CNT_W-1:0]       job_count,
   output logic                   rsp_strobe,
   output logic                   rsp_reg_select,
   output logic [7:0]             rsp_bus_byte,
   output logic                   rsp_last
);

   localparam int DBW = 4 * MAX_DIGITS;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_INIT   = 7'b0000010,
      S_CURSOR = 7'b0000100,
      S_LEAD   = 7'b0001000,
      S_MUL    = 7'b0010000,
      S_DIV    = 7'b0100000,
      S_DIGIT  = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [1:0]                    init_idx_ff, init_idx_in;
   logic [CNT_W-1:0]              left_ff, left_in;
   logic                          strobe_ff, strobe_in;
   logic                          last_ff, last_in;

   clnw_pkg::job_ctrl_type        ctrl_ff, ctrl_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [VALUE_WIDTH-1:0]        num_ff, num_in;
   logic [clnw_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [DBW-1:0]                digits_ff, digits_in;
   logic                          rs_ff, rs_in;
   logic [7:0]                    byte_ff, byte_in;

   logic [2*clnw_pkg::MUL_W-1:0]  product;
   logic [3:0]                    ten_quot_lo;
   logic [3:0]                    digit;

   // The remainder of a division by ten fits in four bits, so the low nibble suffices.
   assign product     = {32'd0, clnw_pkg::MUL_W'(num_ff)} * {32'd0, clnw_pkg::RECIP_TEN};
   assign ten_quot_lo = {quot_ff[0], 3'b000} + {quot_ff[2:0], 1'b0};

   always_comb begin
      case (ctrl_ff.base)
         clnw_pkg::BASE_DEC: digit = num_ff[3:0] - ten_quot_lo;
         clnw_pkg::BASE_BIN: digit = {3'b000, num_ff[0]};
         clnw_pkg::BASE_HEX: digit = num_ff[3:0];
         default:            digit = 4'd0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      init_idx_in = init_idx_ff;
      left_in     = left_ff;
      strobe_in   = 1'b0;
      last_in     = 1'b0;
      ctrl_in     = ctrl_ff;
      count_in    = count_ff;
      num_in      = num_ff;
      quot_in     = quot_ff;
      digits_in   = digits_ff;
      rs_in       = rs_ff;
      byte_in     = byte_ff;
      pop         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop         = 1'b1;
               ctrl_in     = job_ctrl;
               num_in      = job_mag;
               count_in    = job_count;
               left_in     = job_count;
               init_idx_in = 2'd0;
               state_in    = job_ctrl.is_init ? S_INIT : S_CURSOR;
            end
         end
         S_INIT: begin
            strobe_in   = 1'b1;
            rs_in       = clnw_pkg::RS_COMMAND;
            byte_in     = clnw_pkg::INIT_SEQ[init_idx_ff];
            init_idx_in = init_idx_ff + 2'd1;
            if (init_idx_ff == 2'd3) begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CURSOR: begin
            strobe_in = 1'b1;
            rs_in     = clnw_pkg::RS_COMMAND;
            byte_in   = ctrl_ff.cursor;
            if (ctrl_ff.has_lead) begin
               state_in = S_LEAD;
            end else if (count_ff != '0) begin
               state_in = S_MUL;
            end else begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LEAD: begin
            strobe_in = 1'b1;
            rs_in     = clnw_pkg::RS_DATA;
            byte_in   = ctrl_ff.lead_char;
            if (count_ff != '0) begin
               state_in = S_MUL;
            end else begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            quot_in  = product[2*clnw_pkg::MUL_W-1:clnw_pkg::RECIP_SHIFT];
            state_in = S_DIV;
         end
         S_DIV: begin
            // Digits enter at the top, so the most significant one ends up there.
            digits_in = (digits_ff >> 4) | (DBW'(digit) << (DBW - 4));
            case (ctrl_ff.base)
               clnw_pkg::BASE_DEC: num_in = VALUE_WIDTH'(quot_ff);
               clnw_pkg::BASE_BIN: num_in = num_ff >> 1;
               clnw_pkg::BASE_HEX: num_in = num_ff >> 4;
               default:            num_in = num_ff;
            endcase
            if (left_ff == CNT_W'(1)) begin
               left_in  = count_ff;
               state_in = S_DIGIT;
            end else begin
               left_in  = left_ff - CNT_W'(1);
               state_in = S_MUL;
            end
         end
         S_DIGIT: begin
            strobe_in = 1'b1;
            rs_in     = clnw_pkg::RS_DATA;
            byte_in   = clnw_pkg::digit_char(digits_ff[DBW-1:DBW-4]);
            digits_in = digits_ff << 4;
            left_in   = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         init_idx_ff <= 2'd0;
         left_ff     <= '0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_idx_ff <= init_idx_in;
         left_ff     <= left_in;
         strobe_ff   <= strobe_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff   <= ctrl_in;
      count_ff  <= count_in;
      num_ff    <= num_in;
      quot_ff   <= quot_in;
      digits_ff <= digits_in;
      rs_ff     <= rs_in;
      byte_ff   <= byte_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_bus_byte   = byte_ff;
   assign rsp_last       = last_ff;

   `ASSERT_SAME(a_last_ends_job, clock, reset, strobe_ff && last_ff, state_ff == S_IDLE,
      "final write seen while the sequencer is still busy")
   `ASSERT_NEXT(a_no_write_in_conv, clock, reset, state_ff == S_MUL, !strobe_ff,
      "bus write issued during a conversion step")
   `ASSERT_SAME(a_digit_left, clock, reset, state_ff == S_DIGIT || state_ff == S_DIV,
      left_ff != '0, "digit counter empty while digits remain")
   `ASSERT_SAME(a_pop_only_idle, clock, reset, pop, state_ff == S_IDLE && !empty,
      "job taken from the queue outside idle")

endmodule

// ===== dv/lcd_write_checker.sv =====
// Checker for the LCD number writer: predicts the bus writes of every request and compares them.
module lcd_write_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_line,
   input  logic [5:0]  req_column,
   input  logic [15:0] req_value,
   input  logic [4:0]  req_digit_count,
   input  logic [7:0]  req_char_code,
   input  logic        rsp_strobe,
   input  logic        rsp_reg_select,
   input  logic [7:0]  rsp_bus_byte,
   input  logic        rsp_last,
   output int          error_count,
   output int          writes_pending,
   output int          writes_checked
);
   import clnw_pkg::*;

   localparam int DIGIT_LIMIT = 16;

   localparam logic       WRITE_CMD  = 1'b0;
   localparam logic       WRITE_DATA = 1'b1;
   localparam logic [1:0] TOP_LINE   = 2'd1;

   localparam logic [7:0] POWER_ON_BYTES [4] = '{8'h38, 8'h0C, 8'h06, 8'h01};
   localparam logic [7:0] SET_ADDRESS  = 8'h80;
   localparam logic [7:0] SECOND_ROW   = 8'h40;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_PLUS   = 8'h2B;
   localparam logic [7:0] ASCII_MINUS  = 8'h2D;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } bus_write_type;

   bus_write_type expected_writes[$];
   int mismatches = 0;
   int checked = 0;

   initial begin
      error_count    = 0;
      writes_pending = 0;
      writes_checked = 0;
   end

   // Works out the complete write sequence of one request and queues it.
   function automatic void predict_writes(input logic [2:0] action, input logic [1:0] line,
                                          input logic [5:0] column, input logic [15:0] value,
                                          input logic [4:0] digit_count,
                                          input logic [7:0] char_code);
      logic [8:0]    sequence_bytes[$];
      logic [7:0]    address;
      logic [3:0]    digits [DIGIT_LIMIT];
      logic [7:0]    digit_byte;
      int unsigned   radix;
      int unsigned   magnitude;
      int            count;
      bus_write_type entry;
      count     = (digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(digit_count);
      radix     = 0;
      magnitude = 32'(value);
      // Column zero wraps to the top of the byte before the address bit is set.
      address = {2'b00, column} - 8'd1;
      if (line != TOP_LINE) begin
         address = address + SECOND_ROW;
      end
      case (action)
         ACT_INIT: begin
            for (int i = 0; i < 4; i++) begin
               sequence_bytes.push_back({WRITE_CMD, POWER_ON_BYTES[i]});
            end
         end
         ACT_CHAR: begin
            sequence_bytes.push_back({WRITE_CMD, SET_ADDRESS | address});
            sequence_bytes.push_back({WRITE_DATA, char_code});
         end
         ACT_UDEC: begin
            sequence_bytes.push_back({WRITE_CMD, SET_ADDRESS | address});
            radix = 10;
         end
         ACT_SDEC: begin
            sequence_bytes.push_back({WRITE_CMD, SET_ADDRESS | address});
            // Zero takes the minus sign; the most negative value keeps its full magnitude.
            if (!value[15] && value != 16'd0) begin
               sequence_bytes.push_back({WRITE_DATA, ASCII_PLUS});
            end else begin
               sequence_bytes.push_back({WRITE_DATA, ASCII_MINUS});
               magnitude = value[15] ? (32'd65536 - 32'(value)) : 32'd0;
            end
            radix = 10;
         end
         ACT_BIN: begin
            sequence_bytes.push_back({WRITE_CMD, SET_ADDRESS | address});
            radix = 2;
         end
         ACT_HEX: begin
            sequence_bytes.push_back({WRITE_CMD, SET_ADDRESS | address});
            radix = 16;
         end
         default: begin
            return;
         end
      endcase
      if (radix != 0) begin
         for (int p = 0; p < count; p++) begin
            digits[p] = 4'(magnitude % radix);
            magnitude = magnitude / radix;
         end
         for (int p = count - 1; p >= 0; p--) begin
            if (digits[p] < 4'd10) begin
               digit_byte = ASCII_ZERO + {4'd0, digits[p]};
            end else begin
               digit_byte = ASCII_UPPER_A + {4'd0, digits[p]} - 8'd10;
            end
            sequence_bytes.push_back({WRITE_DATA, digit_byte});
         end
      end
      foreach (sequence_bytes[i]) begin
         entry.reg_select = sequence_bytes[i][8];
         entry.bus_byte   = sequence_bytes[i][7:0];
         entry.last       = (i == sequence_bytes.size() - 1);
         expected_writes.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin : watch
      bus_write_type want;
      if (!reset && rsp_strobe) begin
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected write: expected none, got rs=%0b byte=%02h last=%0b",
                     $time, rsp_reg_select, rsp_bus_byte, rsp_last);
            mismatches++;
         end else begin
            want = expected_writes.pop_front();
            checked++;
            if (rsp_reg_select !== want.reg_select) begin
               $display("%0t: reg_select mismatch: expected %0b, got %0b",
                        $time, want.reg_select, rsp_reg_select);
               mismatches++;
            end
            if (rsp_bus_byte !== want.bus_byte) begin
               $display("%0t: bus_byte mismatch: expected %02h, got %02h",
                        $time, want.bus_byte, rsp_bus_byte);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch: expected %0b, got %0b",
                        $time, want.last, rsp_last);
               mismatches++;
            end
         end
      end
      if (!reset && start && !busy) begin
         predict_writes(req_action, req_line, req_column, req_value, req_digit_count,
                        req_char_code);
      end
      // Published with nonblocking updates so the stimulus side reads settled values.
      error_count    <= mismatches;
      writes_checked <= checked;
      writes_pending <= expected_writes.size();
   end

endmodule

// ===== dv/char_lcd_number_writer_unit_test.sv =====
// Testbench top of the LCD number writer: clock, reset, request stimulus and verdict.
module char_lcd_number_writer_unit_test;
   import clnw_pkg::*;

   localparam logic [2:0] ACT_UNDEF_FIRST = 3'd6;
   localparam logic [2:0] ACT_UNDEF_LAST  = 3'd7;
   localparam int         REQUEST_TARGET  = 310;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [1:0]  req_line = '0;
   logic [5:0]  req_column = '0;
   logic [15:0] req_value = '0;
   logic [4:0]  req_digit_count = '0;
   logic [7:0]  req_char_code = '0;
   logic        rsp_strobe;
   logic        rsp_reg_select;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_last;

   int error_count;
   int writes_pending;
   int writes_checked;

   int  action_hits [8];
   int  requests_sent = 0;
   bit  no_gaps = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   char_lcd_number_writer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_line        (req_line),
      .req_column      (req_column),
      .req_value       (req_value),
      .req_digit_count (req_digit_count),
      .req_char_code   (req_char_code),
      .rsp_strobe      (rsp_strobe),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_last        (rsp_last)
   );

   lcd_write_checker write_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_line        (req_line),
      .req_column      (req_column),
      .req_value       (req_value),
      .req_digit_count (req_digit_count),
      .req_char_code   (req_char_code),
      .rsp_strobe      (rsp_strobe),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .writes_pending  (writes_pending),
      .writes_checked  (writes_checked)
   );

   // Called at a rising edge; returns at the edge where the transaction was accepted.
   task automatic send_request(input logic [2:0] action, input logic [1:0] line,
                               input logic [5:0] column, input logic [15:0] value,
                               input logic [4:0] digit_count, input logic [7:0] char_code);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= action;
      req_line        <= line;
      req_column      <= column;
      req_value       <= value;
      req_digit_count <= digit_count;
      req_char_code   <= char_code;
      @(posedge clock);
      while (busy) @(posedge clock);
      action_hits[action]++;
      if (action <= ACT_HEX) begin
         requests_sent++;
      end
   endtask

   task automatic drain_writes();
      start <= 1'b0;
      do @(posedge clock); while (writes_pending != 0);
   endtask

   task automatic send_random_request();
      logic [2:0]  action;
      logic [1:0]  line;
      logic [5:0]  column;
      logic [15:0] value;
      logic [4:0]  digit_count;
      if ($urandom_range(0, 99) < 4) begin
         action = 3'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
      end else begin
         action = 3'($urandom_range(ACT_INIT, ACT_HEX));
      end
      line   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(1, 2));
      column = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 40));
      case ($urandom_range(0, 9))
         0:       value = 16'h0000;
         1:       value = 16'hFFFF;
         2:       value = 16'h8000;
         3:       value = 16'h7FFF;
         4:       value = 16'($urandom_range(0, 99));
         default: value = 16'($urandom_range(0, 16'hFFFF));
      endcase
      digit_count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
      send_request(action, line, column, value, digit_count, 8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: every action, field extremes and the documented odd cases.
      send_request(ACT_INIT, 2'd1, 6'd1, 16'h0000, 5'd0, 8'h00);
      send_request(ACT_CHAR, 2'd1, 6'd1, 16'h0000, 5'd1, 8'h00);
      send_request(ACT_CHAR, 2'd2, 6'd40, 16'hFFFF, 5'd1, 8'hFF);
      send_request(ACT_UDEC, 2'd1, 6'd1, 16'hFFFF, 5'd16, 8'h00);
      send_request(ACT_UDEC, 2'd2, 6'd5, 16'h0000, 5'd5, 8'h00);
      send_request(ACT_SDEC, 2'd1, 6'd3, 16'h7FFF, 5'd5, 8'h00);
      send_request(ACT_SDEC, 2'd2, 6'd3, 16'h8000, 5'd5, 8'h00);
      send_request(ACT_SDEC, 2'd1, 6'd7, 16'h0000, 5'd3, 8'h00);
      send_request(ACT_SDEC, 2'd2, 6'd9, 16'hFFFF, 5'd16, 8'h00);
      send_request(ACT_BIN, 2'd1, 6'd1, 16'hAAAA, 5'd16, 8'h00);
      send_request(ACT_BIN, 2'd2, 6'd1, 16'h5555, 5'd16, 8'h00);
      send_request(ACT_HEX, 2'd1, 6'd20, 16'hFFFF, 5'd4, 8'h00);
      send_request(ACT_HEX, 2'd2, 6'd20, 16'hABCD, 5'd16, 8'h00);
      send_request(ACT_CHAR, 2'd1, 6'd0, 16'h0000, 5'd1, 8'h41);
      send_request(ACT_CHAR, 2'd2, 6'd0, 16'h0000, 5'd1, 8'h42);
      send_request(ACT_UDEC, 2'd1, 6'd10, 16'd1234, 5'd0, 8'h00);
      send_request(ACT_SDEC, 2'd2, 6'd10, 16'hFF85, 5'd0, 8'h00);
      send_request(ACT_HEX, 2'd1, 6'd2, 16'h1F2E, 5'd31, 8'h00);
      send_request(ACT_UNDEF_FIRST, 2'd1, 6'd1, 16'h1234, 5'd4, 8'h55);
      send_request(ACT_UNDEF_LAST, 2'd2, 6'd2, 16'h4321, 5'd4, 8'hAA);
      send_request(ACT_CHAR, 2'd0, 6'd63, 16'h0000, 5'd1, 8'h7E);
      send_request(ACT_UDEC, 2'd3, 6'd63, 16'd40960, 5'd17, 8'h00);
      send_request(ACT_INIT, 2'd3, 6'd63, 16'hFFFF, 5'd31, 8'hFF);

      while (requests_sent < REQUEST_TARGET) begin
         // Every third block of forty transactions runs without any gaps.
         no_gaps = ((requests_sent / 40) % 3 == 1);
         if (!paused && requests_sent >= REQUEST_TARGET / 2) begin
            paused = 1'b1;
            drain_writes();
         end
         send_random_request();
      end

      drain_writes();
      repeat (60) @(posedge clock);
      $display("Sent %0d requests: %0d init, %0d char, %0d unsigned, %0d signed, %0d binary,",
               requests_sent, action_hits[ACT_INIT], action_hits[ACT_CHAR],
               action_hits[ACT_UDEC], action_hits[ACT_SDEC], action_hits[ACT_BIN]);
      $display("%0d hex, plus %0d undefined actions; %0d bus writes checked.",
               action_hits[ACT_HEX], action_hits[ACT_UNDEF_FIRST] + action_hits[ACT_UNDEF_LAST],
               writes_checked);
      if (error_count == 0) begin
         $display("char_lcd_number_writer_unit_test: done, clean");
      end else begin
         $display("char_lcd_number_writer_unit_test: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Timeout with %0d writes still outstanding.", writes_pending);
      $display("char_lcd_number_writer_unit_test: done, errors");
      $finish;
   end

endmodule
